>>> src/crp_pkg.sv
// Shared constants, types and state encoding for the clock page replacement block.
package crp_pkg;

  localparam int PROGRAM_ID_W = 3;
  localparam int PAGE_W       = 16;
  localparam int STAMP_W      = 32;
  localparam int SLOT_W       = 4;
  localparam int CFG_W        = 5;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  localparam int NUM_PROGRAMS_DEFAULT       = 8;
  localparam int FRAMES_PER_PROGRAM_DEFAULT = 16;
  localparam int PAGE_BITS_DEFAULT          = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_COMMIT
  } crp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } crp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass;
    logic out_free;
  } crp_status_t;

endpackage

>>> src/crp_in_if.sv
// Page fault channel: valid, ready and the fault fields.
interface crp_in_if;
  logic                             valid;
  logic                             ready;
  logic [crp_pkg::PROGRAM_ID_W-1:0] program_id;
  logic [crp_pkg::PAGE_W-1:0]       fault_page;
  logic [crp_pkg::STAMP_W-1:0]      time_stamp;

  modport source (output valid, program_id, fault_page, time_stamp, input ready);
  modport sink   (input valid, program_id, fault_page, time_stamp, output ready);
endinterface

>>> src/crp_out_if.sv
// Replacement result channel: valid, ready and the result fields.
interface crp_out_if;
  logic                        valid;
  logic                        ready;
  logic [crp_pkg::SLOT_W-1:0]  frame_slot;
  logic [crp_pkg::PAGE_W-1:0]  inserted_page;
  logic [crp_pkg::PAGE_W-1:0]  evicted_page;
  logic                        evicted_valid;
  logic [crp_pkg::STAMP_W-1:0] stamp_out;

  modport source (output valid, frame_slot, inserted_page, evicted_page, evicted_valid,
                  stamp_out, input ready);
  modport sink   (input valid, frame_slot, inserted_page, evicted_page, evicted_valid,
                  stamp_out, output ready);
endinterface

>>> src/crp_cfg_if.sv
// Configuration write channel carrying the frames_in_use register.
interface crp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [crp_pkg::CFG_W-1:0] frames_in_use;

  modport source (output valid, frames_in_use, input ready);
  modport sink   (input valid, frames_in_use, output ready);
endinterface

>>> src/clock_page_replacement_core.sv
// Top level of the clock (second-chance) page replacement block.
//
// Channels: fault_i takes one page fault per transaction (program, page,
// time stamp); result_o returns exactly one result per fault (frame slot,
// inserted page, evicted page and its flag, stamp). cfg_i writes
// frames_in_use, the ring length the hand sweeps; write it only while idle.
// Each program owns a ring of frames; pages sit in a RAM, reference and
// used bits and the hands sit in flops.
// Timing: a fault is taken in the idle state, then the hand sweep examines
// one frame a cycle (the passed frames plus the victim), then the commit
// state loads the result register. The sweep over the reference bits sets
// the time an item takes. The next fault is taken as soon as the commit
// is done, while the result still waits.
// Stall: a result held on result_o blocks only the next commit; the
// sweep of the following fault goes on meanwhile.
// Reset: all frames empty, hands at frame 0, frames_in_use at 16; no
// clearing pass is needed.
module clock_page_replacement_core #(
  parameter int NUM_PROGRAMS       = crp_pkg::NUM_PROGRAMS_DEFAULT,
  parameter int FRAMES_PER_PROGRAM = crp_pkg::FRAMES_PER_PROGRAM_DEFAULT,
  parameter int PAGE_BITS          = crp_pkg::PAGE_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crp_cfg_if.sink    cfg_i,
  crp_in_if.sink     fault_i,
  crp_out_if.source  result_o
);

  crp_pkg::crp_cmd_t    cmd;
  crp_pkg::crp_status_t status;
  logic                 in_ready;

  assign fault_i.ready = in_ready;

  crp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fault_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  crp_datapath #(
    .NUM_PROGRAMS       (NUM_PROGRAMS),
    .FRAMES_PER_PROGRAM (FRAMES_PER_PROGRAM),
    .PAGE_BITS          (PAGE_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg      (cfg_i),
    .fault    (fault_i),
    .result   (result_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

>>> src/crp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/crp_ctrl.sv
// Controller: sequences load, hand sweep and commit of one page fault.
module crp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  crp_pkg::crp_status_t status_i,
  output crp_pkg::crp_cmd_t    cmd_o
);

  crp_pkg::crp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      crp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = crp_pkg::ST_SWEEP;
      end
      crp_pkg::ST_SWEEP: begin
        // victim found: its page is being read this cycle
        if (!status_i.pass) state_d = crp_pkg::ST_COMMIT;
      end
      crp_pkg::ST_COMMIT: begin
        if (status_i.out_free) state_d = crp_pkg::ST_IDLE;
      end
      default: state_d = crp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      crp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      crp_pkg::ST_SWEEP: begin
        cmd_o.step = status_i.pass;
      end
      crp_pkg::ST_COMMIT: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == crp_pkg::ST_SWEEP)
    else $error("load did not start a sweep");

  a_commit_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> state_q == crp_pkg::ST_IDLE && in_ready_o)
    else $error("commit did not return to idle");

  a_commit_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == crp_pkg::ST_COMMIT) |-> $past(state_q) == crp_pkg::ST_SWEEP)
    else $error("commit state entered without a sweep");

endmodule

>>> src/crp_datapath.sv
// Datapath: frame status bits, hands, page RAM, ring size and result register.
module crp_datapath #(
  parameter int NUM_PROGRAMS       = crp_pkg::NUM_PROGRAMS_DEFAULT,
  parameter int FRAMES_PER_PROGRAM = crp_pkg::FRAMES_PER_PROGRAM_DEFAULT,
  parameter int PAGE_BITS          = crp_pkg::PAGE_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  crp_cfg_if.sink              cfg,
  crp_in_if.sink               fault,
  crp_out_if.source            result,
  input  crp_pkg::crp_cmd_t    cmd_i,
  output crp_pkg::crp_status_t status_o
);

  localparam int PW    = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1;
  localparam int FW    = $clog2(FRAMES_PER_PROGRAM);
  localparam int NW    = $clog2(FRAMES_PER_PROGRAM + 1);
  localparam int CW    = (NW > crp_pkg::CFG_W) ? NW : crp_pkg::CFG_W;
  localparam int DEPTH = NUM_PROGRAMS * FRAMES_PER_PROGRAM;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = (PAGE_BITS > crp_pkg::PAGE_W) ? PAGE_BITS : crp_pkg::PAGE_W;
  localparam int SW    = (FW > crp_pkg::SLOT_W) ? FW : crp_pkg::SLOT_W;
  localparam int NID   = 2 ** crp_pkg::PROGRAM_ID_W;

  function automatic logic [PW-1:0] prog_mod(input logic [crp_pkg::PROGRAM_ID_W-1:0] id);
    logic [PW-1:0] r;
    r = '0;
    for (int i = 0; i < NID; i++) begin
      if (id == crp_pkg::PROGRAM_ID_W'(i)) r = PW'(i % NUM_PROGRAMS);
    end
    return r;
  endfunction

  logic [crp_pkg::CFG_W-1:0] cfg_q;
  logic [FW-1:0]             hand_q [NUM_PROGRAMS];
  logic [DEPTH-1:0]          used_q;
  logic [DEPTH-1:0]          ref_q;
  logic [PW-1:0]             prog_q;
  logic [FW-1:0]             h_q;
  logic [PAGE_BITS-1:0]      page_q;
  logic [crp_pkg::STAMP_W-1:0] stamp_q;

  logic                         out_valid_q;
  logic [crp_pkg::SLOT_W-1:0]   out_slot_q;
  logic [crp_pkg::PAGE_W-1:0]   out_ins_q;
  logic [crp_pkg::PAGE_W-1:0]   out_ev_q;
  logic                         out_evv_q;
  logic [crp_pkg::STAMP_W-1:0]  out_stamp_q;

  logic [CW-1:0]        cfg_ext, frames_c, ring_n, h_inc;
  logic [FW-1:0]        h_step, hand_sel, h_load;
  logic [PW-1:0]        prog_in;
  logic [AW-1:0]        idx;
  logic [PAGE_BITS-1:0] rdata;
  logic [XW-1:0]        fault_ext, page_ext, ev_ext;
  logic [SW-1:0]        slot_ext;
  logic                 evict;

  assign cfg.ready = 1'b1;

  // Clamp the programmed frame count into 1..FRAMES_PER_PROGRAM.
  assign cfg_ext  = CW'(cfg_q);
  assign frames_c = CW'(FRAMES_PER_PROGRAM);
  assign ring_n   = (cfg_q == '0) ? CW'(1) : ((cfg_ext > frames_c) ? frames_c : cfg_ext);

  assign h_inc  = CW'(h_q) + CW'(1);
  assign h_step = (h_inc == ring_n) ? '0 : FW'(h_inc);

  assign prog_in  = prog_mod(fault.program_id);
  assign hand_sel = hand_q[prog_in];
  // restart a hand left beyond a shrunk ring
  assign h_load   = (CW'(hand_sel) >= ring_n) ? '0 : hand_sel;

  assign idx = AW'(prog_q) * AW'(FRAMES_PER_PROGRAM) + AW'(h_q);

  assign fault_ext = XW'(fault.fault_page);
  assign page_ext  = XW'(page_q);
  assign evict     = used_q[idx];
  assign ev_ext    = evict ? XW'(rdata) : '0;
  assign slot_ext  = SW'(h_q);

  assign status_o.pass     = used_q[idx] && ref_q[idx];
  assign status_o.out_free = !out_valid_q || result.ready;

  crp_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (DEPTH)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (idx),
    .wdata_i (page_q),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= crp_pkg::FRAMES_IN_USE_RESET;
      used_q      <= '0;
      ref_q       <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < NUM_PROGRAMS; p++) begin
        hand_q[p] <= '0;
      end
    end else begin
      if (cfg.valid) cfg_q <= cfg.frames_in_use;
      if (cmd_i.step) ref_q[idx] <= 1'b0;
      if (cmd_i.commit) begin
        used_q[idx]    <= 1'b1;
        ref_q[idx]     <= 1'b1;
        hand_q[prog_q] <= h_step;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (result.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prog_q  <= prog_in;
      h_q     <= h_load;
      page_q  <= fault_ext[PAGE_BITS-1:0];
      stamp_q <= fault.time_stamp;
    end else if (cmd_i.step) begin
      h_q <= h_step;
    end
    if (cmd_i.commit) begin
      out_slot_q  <= slot_ext[crp_pkg::SLOT_W-1:0];
      out_ins_q   <= page_ext[crp_pkg::PAGE_W-1:0];
      out_ev_q    <= ev_ext[crp_pkg::PAGE_W-1:0];
      out_evv_q   <= evict;
      out_stamp_q <= stamp_q;
    end
  end

  assign result.valid         = out_valid_q;
  assign result.frame_slot    = out_slot_q;
  assign result.inserted_page = out_ins_q;
  assign result.evicted_page  = out_ev_q;
  assign result.evicted_valid = out_evv_q;
  assign result.stamp_out     = out_stamp_q;

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("result raised without a commit");

  a_hand_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step || cmd_i.commit) |-> CW'(h_q) < ring_n)
    else $error("hand outside the ring");

  a_step_clears_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> !ref_q[$past(idx)])
    else $error("passed frame kept its reference bit");

  a_commit_marks_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> used_q[$past(idx)] && ref_q[$past(idx)])
    else $error("committed frame not marked used and referenced");

endmodule
